// ===== design/mid_pkg.sv =====
`default_nettype none
package mid_pkg;

    localparam logic [7:0] MN_ROTR    = 8'd135;
    localparam logic [7:0] MN_ROTRV   = 8'd136;
    localparam logic [7:0] MN_DROTRV  = 8'd137;
    localparam logic [7:0] MN_DROTR   = 8'd138;
    localparam logic [7:0] MN_DROTR32 = 8'd139;
    localparam logic [7:0] MN_NOP     = 8'd140;
    localparam logic [7:0] MN_MOVE    = 8'd141;
    localparam logic [7:0] MN_LI      = 8'd142;

    localparam logic [4:0] F_DST  = 5'd0;
    localparam logic [4:0] F_ST   = 5'd1;
    localparam logic [4:0] F_TD   = 5'd2;
    localparam logic [4:0] F_DS   = 5'd3;
    localparam logic [4:0] F_DT   = 5'd4;
    localparam logic [4:0] F_D    = 5'd5;
    localparam logic [4:0] F_S    = 5'd6;
    localparam logic [4:0] F_SDT  = 5'd7;
    localparam logic [4:0] F_FTS  = 5'd8;
    localparam logic [4:0] F_BS   = 5'd9;
    localparam logic [4:0] F_BTS  = 5'd10;
    localparam logic [4:0] F_TS   = 5'd11;
    localparam logic [4:0] F_J    = 5'd12;
    localparam logic [4:0] F_ATS  = 5'd13;
    localparam logic [4:0] F_LT   = 5'd14;
    localparam logic [4:0] F_LTS  = 5'd15;
    localparam logic [4:0] F_MTS  = 5'd16;
    localparam logic [4:0] F_MS   = 5'd17;
    localparam logic [4:0] F_CODE = 5'd18;

    localparam logic [5:0] OP_SPC    = 6'h00;
    localparam logic [5:0] OP_RIMM   = 6'h01;
    localparam logic [5:0] OP_ORI    = 6'h0D;
    localparam logic [5:0] OP_SPC2   = 6'h1C;
    localparam logic [5:0] OP_SPC3   = 6'h1F;
    localparam logic [5:0] FN_BSWAP  = 6'h20;
    localparam logic [5:0] FN_DBSWAP = 6'h24;
    localparam logic [5:0] FN_OR     = 6'h25;

    // Lookup result: hit, mnemonic, form, and the rotate alternate (0 if none).
    typedef struct packed {
        logic       hit;
        logic [7:0] mn;
        logic [4:0] form;
        logic [7:0] alt;
    } lut_t;

    function automatic lut_t ent(input logic [7:0] mn, input logic [4:0] form,
                                 input logic [7:0] alt);
        lut_t r;
        r.hit  = 1'b1;
        r.mn   = mn;
        r.form = form;
        r.alt  = alt;
        return r;
    endfunction

    function automatic lut_t lut_special(input logic [5:0] c);
        lut_t r;
        r = '0;
        case (c)
            6'h00: r = ent(8'd0, F_SDT, 8'd0);
            6'h02: r = ent(8'd1, F_SDT, MN_ROTR);
            6'h03: r = ent(8'd2, F_SDT, 8'd0);
            6'h04: r = ent(8'd3, F_DST, 8'd0);
            6'h06: r = ent(8'd4, F_DST, MN_ROTRV);
            6'h07: r = ent(8'd5, F_DST, 8'd0);
            6'h08: r = ent(8'd6, F_S, 8'd0);
            6'h09: r = ent(8'd7, F_DS, 8'd0);
            6'h0a: r = ent(8'd8, F_DST, 8'd0);
            6'h0b: r = ent(8'd9, F_DST, 8'd0);
            6'h0c: r = ent(8'd10, F_CODE, 8'd0);
            6'h0d: r = ent(8'd11, F_CODE, 8'd0);
            6'h10: r = ent(8'd12, F_D, 8'd0);
            6'h11: r = ent(8'd13, F_S, 8'd0);
            6'h12: r = ent(8'd14, F_D, 8'd0);
            6'h13: r = ent(8'd15, F_S, 8'd0);
            6'h14: r = ent(8'd16, F_DST, 8'd0);
            6'h16: r = ent(8'd17, F_DST, MN_DROTRV);
            6'h17: r = ent(8'd18, F_DST, 8'd0);
            6'h18: r = ent(8'd19, F_ST, 8'd0);
            6'h19: r = ent(8'd20, F_ST, 8'd0);
            6'h1a: r = ent(8'd21, F_ST, 8'd0);
            6'h1b: r = ent(8'd22, F_ST, 8'd0);
            6'h1c: r = ent(8'd23, F_ST, 8'd0);
            6'h1d: r = ent(8'd24, F_ST, 8'd0);
            6'h1e: r = ent(8'd25, F_ST, 8'd0);
            6'h1f: r = ent(8'd26, F_ST, 8'd0);
            6'h20: r = ent(8'd27, F_DST, 8'd0);
            6'h21: r = ent(8'd28, F_DST, 8'd0);
            6'h22: r = ent(8'd29, F_DST, 8'd0);
            6'h23: r = ent(8'd30, F_DST, 8'd0);
            6'h24: r = ent(8'd31, F_DST, 8'd0);
            6'h25: r = ent(8'd32, F_DST, 8'd0);
            6'h26: r = ent(8'd33, F_DST, 8'd0);
            6'h27: r = ent(8'd34, F_DST, 8'd0);
            6'h2a: r = ent(8'd35, F_DST, 8'd0);
            6'h2b: r = ent(8'd36, F_DST, 8'd0);
            6'h2c: r = ent(8'd37, F_DST, 8'd0);
            6'h2d: r = ent(8'd38, F_DST, 8'd0);
            6'h2e: r = ent(8'd39, F_DST, 8'd0);
            6'h2f: r = ent(8'd40, F_DST, 8'd0);
            6'h30: r = ent(8'd41, F_ST, 8'd0);
            6'h31: r = ent(8'd42, F_ST, 8'd0);
            6'h32: r = ent(8'd43, F_ST, 8'd0);
            6'h33: r = ent(8'd44, F_ST, 8'd0);
            6'h34: r = ent(8'd45, F_ST, 8'd0);
            6'h36: r = ent(8'd46, F_ST, 8'd0);
            6'h38: r = ent(8'd47, F_SDT, 8'd0);
            6'h3a: r = ent(8'd48, F_SDT, MN_DROTR);
            6'h3b: r = ent(8'd49, F_SDT, 8'd0);
            6'h3c: r = ent(8'd50, F_SDT, 8'd0);
            6'h3e: r = ent(8'd51, F_SDT, MN_DROTR32);
            6'h3f: r = ent(8'd52, F_SDT, 8'd0);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic lut_t lut_special2(input logic [5:0] c);
        lut_t r;
        r = '0;
        case (c)
            6'h00: r = ent(8'd53, F_ST, 8'd0);
            6'h01: r = ent(8'd54, F_ST, 8'd0);
            6'h02: r = ent(8'd55, F_ST, 8'd0);
            6'h04: r = ent(8'd56, F_ST, 8'd0);
            6'h05: r = ent(8'd57, F_ST, 8'd0);
            6'h20: r = ent(8'd58, F_DS, 8'd0);
            6'h21: r = ent(8'd59, F_DS, 8'd0);
            6'h24: r = ent(8'd60, F_DS, 8'd0);
            6'h25: r = ent(8'd61, F_DS, 8'd0);
            6'h37: r = ent(8'd62, F_CODE, 8'd0);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic lut_t lut_special3(input logic [5:0] fn, input logic [4:0] sa);
        lut_t r;
        r = '0;
        if (fn == FN_BSWAP)
        begin
            case (sa)
                5'h02: r = ent(8'd72, F_DT, 8'd0);
                5'h10: r = ent(8'd73, F_DT, 8'd0);
                5'h18: r = ent(8'd74, F_DT, 8'd0);
                default: r = '0;
            endcase
        end
        else if (fn == FN_DBSWAP)
        begin
            case (sa)
                5'h02: r = ent(8'd75, F_DT, 8'd0);
                5'h05: r = ent(8'd76, F_DT, 8'd0);
                default: r = '0;
            endcase
        end
        else
        begin
            case (fn)
                6'h00, 6'h01, 6'h02, 6'h03, 6'h04, 6'h05, 6'h06, 6'h07:
                    r = ent(8'd63 + {5'd0, fn[2:0]}, F_FTS, 8'd0);
                6'h3b: r = ent(8'd71, F_TD, 8'd0);
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    function automatic lut_t lut_regimm(input logic [4:0] c);
        lut_t r;
        r = '0;
        case (c)
            5'h00: r = ent(8'd77, F_BS, 8'd0);
            5'h01: r = ent(8'd78, F_BS, 8'd0);
            5'h02: r = ent(8'd79, F_BS, 8'd0);
            5'h03: r = ent(8'd80, F_BS, 8'd0);
            5'h08: r = ent(8'd81, F_TS, 8'd0);
            5'h09: r = ent(8'd82, F_TS, 8'd0);
            5'h0a: r = ent(8'd83, F_TS, 8'd0);
            5'h0b: r = ent(8'd84, F_TS, 8'd0);
            5'h0c: r = ent(8'd85, F_TS, 8'd0);
            5'h0e: r = ent(8'd86, F_TS, 8'd0);
            5'h10: r = ent(8'd87, F_BS, 8'd0);
            5'h11: r = ent(8'd88, F_BS, 8'd0);
            5'h12: r = ent(8'd89, F_BS, 8'd0);
            5'h13: r = ent(8'd90, F_BS, 8'd0);
            5'h1f: r = ent(8'd91, F_MS, 8'd0);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic lut_t lut_primary(input logic [5:0] c);
        lut_t r;
        r = '0;
        case (c)
            6'h02: r = ent(8'd92, F_J, 8'd0);
            6'h03: r = ent(8'd93, F_J, 8'd0);
            6'h04: r = ent(8'd94, F_BTS, 8'd0);
            6'h05: r = ent(8'd95, F_BTS, 8'd0);
            6'h06: r = ent(8'd96, F_BS, 8'd0);
            6'h07: r = ent(8'd97, F_BS, 8'd0);
            6'h08: r = ent(8'd98, F_ATS, 8'd0);
            6'h09: r = ent(8'd99, F_ATS, 8'd0);
            6'h0a: r = ent(8'd100, F_ATS, 8'd0);
            6'h0b: r = ent(8'd101, F_ATS, 8'd0);
            6'h0c: r = ent(8'd102, F_LTS, 8'd0);
            6'h0d: r = ent(8'd103, F_LTS, 8'd0);
            6'h0e: r = ent(8'd104, F_LTS, 8'd0);
            6'h0f: r = ent(8'd105, F_LT, 8'd0);
            6'h14: r = ent(8'd106, F_BTS, 8'd0);
            6'h15: r = ent(8'd107, F_BTS, 8'd0);
            6'h16: r = ent(8'd108, F_BS, 8'd0);
            6'h17: r = ent(8'd109, F_BS, 8'd0);
            6'h18: r = ent(8'd110, F_ATS, 8'd0);
            6'h19: r = ent(8'd111, F_ATS, 8'd0);
            6'h1a: r = ent(8'd112, F_MTS, 8'd0);
            6'h1b: r = ent(8'd113, F_MTS, 8'd0);
            6'h20: r = ent(8'd114, F_MTS, 8'd0);
            6'h21: r = ent(8'd115, F_MTS, 8'd0);
            6'h22: r = ent(8'd116, F_MTS, 8'd0);
            6'h23: r = ent(8'd117, F_MTS, 8'd0);
            6'h24: r = ent(8'd118, F_MTS, 8'd0);
            6'h25: r = ent(8'd119, F_MTS, 8'd0);
            6'h26: r = ent(8'd120, F_MTS, 8'd0);
            6'h27: r = ent(8'd121, F_MTS, 8'd0);
            6'h28: r = ent(8'd122, F_MTS, 8'd0);
            6'h29: r = ent(8'd123, F_MTS, 8'd0);
            6'h2a: r = ent(8'd124, F_MTS, 8'd0);
            6'h2b: r = ent(8'd125, F_MTS, 8'd0);
            6'h2c: r = ent(8'd126, F_MTS, 8'd0);
            6'h2d: r = ent(8'd127, F_MTS, 8'd0);
            6'h2e: r = ent(8'd128, F_MTS, 8'd0);
            6'h30: r = ent(8'd129, F_MTS, 8'd0);
            6'h34: r = ent(8'd130, F_MTS, 8'd0);
            6'h37: r = ent(8'd131, F_MTS, 8'd0);
            6'h38: r = ent(8'd132, F_MTS, 8'd0);
            6'h3c: r = ent(8'd133, F_MTS, 8'd0);
            6'h3f: r = ent(8'd134, F_MTS, 8'd0);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/mips_instruction_decoder_unit.sv =====
`default_nettype none
// Three register stages: input register (stage 0), lookup register (stage 1)
// and output register (stage 3).
// One instruction word per cycle unless stalled; stage 1 does the table lookup,
// stage 2 builds the operand fields and adds the branch offset, stage 3 holds
// the result. A stall freezes the whole pipeline when the output is full.
// Reset (rst_n, asynchronous, active low) clears all stage valid bits only.
module mips_instruction_decoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] pc,
    input  wire logic [31:0] instruction_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             decoded,
    output logic [7:0]       mnemonic,
    output logic [4:0]       operand_form,
    output logic [4:0]       first_reg,
    output logic [4:0]       second_reg,
    output logic [4:0]       third_reg,
    output logic signed [20:0] first_number,
    output logic [6:0]       second_number,
    output logic [63:0]      target_address,
    output logic             has_target
);
    import mid_pkg::*;

    // The pipeline advances as a whole whenever the last stage can move on.
    logic advance;
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    // Stage 0: input register.
    logic        v0_reg;
    logic [63:0] pc0_reg;
    logic [31:0] w0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (advance)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            pc0_reg <= pc;
            w0_reg  <= instruction_word;
        end
    end

    // Stage 1: group selection and table lookup.
    logic [5:0] op0, fn0;
    lut_t       lut_next;
    assign op0 = w0_reg[31:26];
    assign fn0 = w0_reg[5:0];

    always_comb
    begin
        case (op0)
            OP_SPC:  lut_next = lut_special(fn0);
            OP_SPC2: lut_next = lut_special2(fn0);
            OP_SPC3: lut_next = lut_special3(fn0, w0_reg[10:6]);
            OP_RIMM: lut_next = lut_regimm(w0_reg[20:16]);
            default: lut_next = lut_primary(op0);
        endcase
    end

    logic        v1_reg;
    lut_t        lut1_reg;
    logic [63:0] pc1_reg;
    logic [31:0] w1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (advance)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lut1_reg <= lut_next;
            pc1_reg  <= pc0_reg;
            w1_reg   <= w0_reg;
        end
    end

    // Stage 2: operand extraction per form, target computation.
    logic [31:0] w;
    logic [4:0]  rs, rt, rd, sa;
    logic [20:0] simm, uimm;
    logic [7:0]  mn_c;
    logic [4:0]  form_c;
    logic [4:0]  r1_c, r2_c, r3_c;
    logic [20:0] num_c;
    logic [6:0]  size_c;
    logic [63:0] tgt_c;
    logic        has_c;
    logic signed [7:0] ssize;

    assign w    = w1_reg;
    assign rs   = w[25:21];
    assign rt   = w[20:16];
    assign rd   = w[15:11];
    assign sa   = w[10:6];
    assign simm = {{5{w[15]}}, w[15:0]};
    assign uimm = {5'd0, w[15:0]};

    always_comb
    begin
        mn_c   = lut1_reg.mn;
        form_c = lut1_reg.form;
        r1_c   = '0;
        r2_c   = '0;
        r3_c   = '0;
        num_c  = '0;
        size_c = '0;
        tgt_c  = '0;
        has_c  = 1'b0;
        ssize  = '0;
        case (lut1_reg.form)
            F_DST:
            begin
                if (w[5:0] == FN_OR && rt == 5'd0)
                begin
                    mn_c   = MN_MOVE;
                    form_c = F_DS;
                    r1_c   = rd;
                    r2_c   = rs;
                end
                else
                begin
                    if (lut1_reg.alt != 8'd0 && w[6])
                        mn_c = lut1_reg.alt;
                    r1_c = rd;
                    r2_c = rs;
                    r3_c = rt;
                end
            end
            F_ST:
            begin
                r1_c = rs;
                r2_c = rt;
                // Register-register traps carry a 10-bit code.
                if (w[5:3] == 3'b110)
                    num_c = {11'd0, w[15:6]};
            end
            F_TD: begin r1_c = rt; r2_c = rd; end
            F_DS: begin r1_c = rd; r2_c = rs; end
            F_DT: begin r1_c = rd; r2_c = rt; end
            F_D:  r1_c = rd;
            F_S:  r1_c = rs;
            F_SDT:
            begin
                if (w == 32'd0)
                    mn_c = MN_NOP;
                else
                begin
                    if (lut1_reg.alt != 8'd0 && w[21])
                        mn_c = lut1_reg.alt;
                    r1_c  = rd;
                    r2_c  = rt;
                    num_c = {16'd0, sa};
                end
            end
            F_FTS:
            begin
                r1_c = rt;
                r2_c = rs;
                case (w[2:0])
                    3'd0, 3'd3:
                    begin
                        num_c = {16'd0, sa};
                        ssize = {3'd0, rd} + 8'sd1;
                    end
                    3'd1:
                    begin
                        num_c = {16'd0, sa};
                        ssize = {3'd0, rd} + 8'sd33;
                    end
                    3'd2:
                    begin
                        num_c = {16'd0, sa} + 21'd32;
                        ssize = {3'd0, rd} + 8'sd1;
                    end
                    3'd5:
                    begin
                        num_c = {16'd0, sa};
                        ssize = {3'd0, rd} + 8'sd33 - {3'd0, sa};
                    end
                    3'd6:
                    begin
                        num_c = {16'd0, sa} + 21'd32;
                        ssize = {3'd0, rd} + 8'sd1 - {3'd0, sa};
                    end
                    default:
                    begin
                        num_c = {16'd0, sa};
                        ssize = {3'd0, rd} + 8'sd1 - {3'd0, sa};
                    end
                endcase
                size_c = ssize[7] ? 7'd0 : ssize[6:0];
            end
            F_BS, F_BTS:
            begin
                r1_c = rs;
                if (lut1_reg.form == F_BTS)
                    r2_c = rt;
                tgt_c = pc1_reg + 64'd4 + {{46{w[15]}}, w[15:0], 2'b00};
                has_c = 1'b1;
            end
            F_J:
            begin
                tgt_c = {pc1_reg[63:28], w[25:0], 2'b00};
                has_c = 1'b1;
            end
            F_LT: begin r1_c = rt; num_c = uimm; end
            F_LTS:
            begin
                if (w[31:26] == OP_ORI && rs == 5'd0)
                begin
                    mn_c   = MN_LI;
                    form_c = F_LT;
                    r1_c   = rt;
                end
                else
                begin
                    r1_c = rt;
                    r2_c = rs;
                end
                num_c = uimm;
            end
            F_ATS, F_MTS: begin r1_c = rt; r2_c = rs; num_c = simm; end
            F_MS, F_TS:   begin r1_c = rs; num_c = simm; end
            default:      num_c = {1'b0, w[25:6]};
        endcase
    end

    // Stage 3: output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (advance)
            out_valid <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            decoded        <= lut1_reg.hit;
            mnemonic       <= lut1_reg.hit ? mn_c : 8'd0;
            operand_form   <= lut1_reg.hit ? form_c : 5'd0;
            first_reg      <= lut1_reg.hit ? r1_c : 5'd0;
            second_reg     <= lut1_reg.hit ? r2_c : 5'd0;
            third_reg      <= lut1_reg.hit ? r3_c : 5'd0;
            first_number   <= lut1_reg.hit ? num_c : 21'd0;
            second_number  <= lut1_reg.hit ? size_c : 7'd0;
            target_address <= lut1_reg.hit ? tgt_c : 64'd0;
            has_target     <= lut1_reg.hit && has_c;
        end
    end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mid_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_OFF_LEN   = 200;

    // One expected or observed decode result.
    typedef struct packed {
        logic              decoded;
        logic [7:0]        mnemonic;
        logic [4:0]        operand_form;
        logic [4:0]        first_reg;
        logic [4:0]        second_reg;
        logic [4:0]        third_reg;
        logic signed [20:0] first_number;
        logic [6:0]        second_number;
        logic [63:0]       target_address;
        logic              has_target;
    } decode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] pc;
    logic [31:0] instruction_word;
    logic        out_valid;
    logic        out_stall;
    logic        decoded;
    logic [7:0]  mnemonic;
    logic [4:0]  operand_form;
    logic [4:0]  first_reg;
    logic [4:0]  second_reg;
    logic [4:0]  third_reg;
    logic signed [20:0] first_number;
    logic [6:0]  second_number;
    logic [63:0] target_address;
    logic        has_target;

    mips_instruction_decoder_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pc(pc), .instruction_word(instruction_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .decoded(decoded), .mnemonic(mnemonic), .operand_form(operand_form),
        .first_reg(first_reg), .second_reg(second_reg), .third_reg(third_reg),
        .first_number(first_number), .second_number(second_number),
        .target_address(target_address), .has_target(has_target)
    );

    decode_t pending_decodes[$];
    int      mismatch_count = 0;
    int      result_count = 0;
    int      idle_cycles = 0;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_off_requests = 0;
    int      hold_off_served;
    int      hold_off_cycles;
    bit      timed_out = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Opcode lookup: returns hit, row number, form and the rotate alternate,
    // using the grouping of the primary opcode, SPECIAL, SPECIAL2, SPECIAL3
    // (with the two byte-shuffle subgroups) and REGIMM tables.
    function automatic void lookup_opcode(input logic [31:0] w, output bit hit,
                                          output logic [7:0] row,
                                          output logic [4:0] form,
                                          output logic [7:0] alt);
        logic [5:0] op;
        logic [5:0] fn;
        logic [4:0] rt;
        logic [4:0] sa;
        op = w[31:26];
        fn = w[5:0];
        rt = w[20:16];
        sa = w[10:6];
        hit = 1'b1;
        alt = 8'd0;
        row = 8'd0;
        form = F_DST;
        if (op == OP_SPC)
        begin
            case (fn)
                6'h00: begin row = 0; form = F_SDT; end
                6'h02: begin row = 1; form = F_SDT; alt = MN_ROTR; end
                6'h03: begin row = 2; form = F_SDT; end
                6'h04: begin row = 3; form = F_DST; end
                6'h06: begin row = 4; form = F_DST; alt = MN_ROTRV; end
                6'h07: begin row = 5; form = F_DST; end
                6'h08: begin row = 6; form = F_S; end
                6'h09: begin row = 7; form = F_DS; end
                6'h0a: begin row = 8; form = F_DST; end
                6'h0b: begin row = 9; form = F_DST; end
                6'h0c: begin row = 10; form = F_CODE; end
                6'h0d: begin row = 11; form = F_CODE; end
                6'h10: begin row = 12; form = F_D; end
                6'h11: begin row = 13; form = F_S; end
                6'h12: begin row = 14; form = F_D; end
                6'h13: begin row = 15; form = F_S; end
                6'h14: begin row = 16; form = F_DST; end
                6'h16: begin row = 17; form = F_DST; alt = MN_DROTRV; end
                6'h17: begin row = 18; form = F_DST; end
                6'h18, 6'h19, 6'h1a, 6'h1b, 6'h1c, 6'h1d, 6'h1e, 6'h1f:
                begin
                    row = 8'd19 + 8'(fn - 6'h18);
                    form = F_ST;
                end
                6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27:
                begin
                    row = 8'd27 + 8'(fn - 6'h20);
                    form = F_DST;
                end
                6'h2a, 6'h2b, 6'h2c, 6'h2d, 6'h2e, 6'h2f:
                begin
                    row = 8'd35 + 8'(fn - 6'h2a);
                    form = F_DST;
                end
                6'h30, 6'h31, 6'h32, 6'h33, 6'h34:
                begin
                    row = 8'd41 + 8'(fn - 6'h30);
                    form = F_ST;
                end
                6'h36: begin row = 46; form = F_ST; end
                6'h38: begin row = 47; form = F_SDT; end
                6'h3a: begin row = 48; form = F_SDT; alt = MN_DROTR; end
                6'h3b: begin row = 49; form = F_SDT; end
                6'h3c: begin row = 50; form = F_SDT; end
                6'h3e: begin row = 51; form = F_SDT; alt = MN_DROTR32; end
                6'h3f: begin row = 52; form = F_SDT; end
                default: hit = 1'b0;
            endcase
        end
        else if (op == OP_SPC2)
        begin
            case (fn)
                6'h00: begin row = 53; form = F_ST; end
                6'h01: begin row = 54; form = F_ST; end
                6'h02: begin row = 55; form = F_ST; end
                6'h04: begin row = 56; form = F_ST; end
                6'h05: begin row = 57; form = F_ST; end
                6'h20: begin row = 58; form = F_DS; end
                6'h21: begin row = 59; form = F_DS; end
                6'h24: begin row = 60; form = F_DS; end
                6'h25: begin row = 61; form = F_DS; end
                6'h37: begin row = 62; form = F_CODE; end
                default: hit = 1'b0;
            endcase
        end
        else if (op == OP_SPC3)
        begin
            if (fn == FN_BSWAP)
            begin
                case (sa)
                    5'h02: begin row = 72; form = F_DT; end
                    5'h10: begin row = 73; form = F_DT; end
                    5'h18: begin row = 74; form = F_DT; end
                    default: hit = 1'b0;
                endcase
            end
            else if (fn == FN_DBSWAP)
            begin
                case (sa)
                    5'h02: begin row = 75; form = F_DT; end
                    5'h05: begin row = 76; form = F_DT; end
                    default: hit = 1'b0;
                endcase
            end
            else if (fn < 6'h08)
            begin
                row = 8'd63 + 8'(fn);
                form = F_FTS;
            end
            else if (fn == 6'h3b)
            begin
                row = 71;
                form = F_TD;
            end
            else
                hit = 1'b0;
        end
        else if (op == OP_RIMM)
        begin
            case (rt)
                5'h00: begin row = 77; form = F_BS; end
                5'h01: begin row = 78; form = F_BS; end
                5'h02: begin row = 79; form = F_BS; end
                5'h03: begin row = 80; form = F_BS; end
                5'h08: begin row = 81; form = F_TS; end
                5'h09: begin row = 82; form = F_TS; end
                5'h0a: begin row = 83; form = F_TS; end
                5'h0b: begin row = 84; form = F_TS; end
                5'h0c: begin row = 85; form = F_TS; end
                5'h0e: begin row = 86; form = F_TS; end
                5'h10: begin row = 87; form = F_BS; end
                5'h11: begin row = 88; form = F_BS; end
                5'h12: begin row = 89; form = F_BS; end
                5'h13: begin row = 90; form = F_BS; end
                5'h1f: begin row = 91; form = F_MS; end
                default: hit = 1'b0;
            endcase
        end
        else
        begin
            case (op)
                6'h02: begin row = 92; form = F_J; end
                6'h03: begin row = 93; form = F_J; end
                6'h04: begin row = 94; form = F_BTS; end
                6'h05: begin row = 95; form = F_BTS; end
                6'h06: begin row = 96; form = F_BS; end
                6'h07: begin row = 97; form = F_BS; end
                6'h08, 6'h09, 6'h0a, 6'h0b:
                begin
                    row = 8'd98 + 8'(op - 6'h08);
                    form = F_ATS;
                end
                6'h0c, 6'h0d, 6'h0e:
                begin
                    row = 8'd102 + 8'(op - 6'h0c);
                    form = F_LTS;
                end
                6'h0f: begin row = 105; form = F_LT; end
                6'h14: begin row = 106; form = F_BTS; end
                6'h15: begin row = 107; form = F_BTS; end
                6'h16: begin row = 108; form = F_BS; end
                6'h17: begin row = 109; form = F_BS; end
                6'h18: begin row = 110; form = F_ATS; end
                6'h19: begin row = 111; form = F_ATS; end
                6'h1a: begin row = 112; form = F_MTS; end
                6'h1b: begin row = 113; form = F_MTS; end
                6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27,
                6'h28, 6'h29, 6'h2a, 6'h2b, 6'h2c, 6'h2d, 6'h2e:
                begin
                    row = 8'd114 + 8'(op - 6'h20);
                    form = F_MTS;
                end
                6'h30: begin row = 129; form = F_MTS; end
                6'h34: begin row = 130; form = F_MTS; end
                6'h37: begin row = 131; form = F_MTS; end
                6'h38: begin row = 132; form = F_MTS; end
                6'h3c: begin row = 133; form = F_MTS; end
                6'h3f: begin row = 134; form = F_MTS; end
                default: hit = 1'b0;
            endcase
        end
    endfunction

    // Full decode of one word into the result fields.
    function automatic decode_t decode_word(input logic [63:0] addr, input logic [31:0] w);
        decode_t    d;
        bit         hit;
        logic [7:0] row;
        logic [7:0] alt;
        logic [4:0] form;
        logic [4:0] rs;
        logic [4:0] rt;
        logic [4:0] rd;
        logic [4:0] sa;
        logic signed [20:0] simm;
        logic signed [20:0] uimm;
        int         size;
        int         pos;
        rs = w[25:21];
        rt = w[20:16];
        rd = w[15:11];
        sa = w[10:6];
        simm = 21'(signed'(w[15:0]));
        uimm = {5'd0, w[15:0]};
        d = '0;
        lookup_opcode(w, hit, row, form, alt);
        if (!hit)
            return d;
        d.decoded = 1'b1;
        d.mnemonic = row;
        case (form)
            F_DST:
            begin
                if (w[5:0] == FN_OR && rt == 5'd0)
                begin
                    d.mnemonic = MN_MOVE;
                    form = F_DS;
                    d.first_reg = rd;
                    d.second_reg = rs;
                end
                else
                begin
                    if (alt != 8'd0 && w[6])
                        d.mnemonic = alt;
                    d.first_reg = rd;
                    d.second_reg = rs;
                    d.third_reg = rt;
                end
            end
            F_ST:
            begin
                d.first_reg = rs;
                d.second_reg = rt;
                // Register traps carry a 10-bit code.
                if (w[5:3] == 3'b110)
                    d.first_number = {11'd0, w[15:6]};
            end
            F_TD: begin d.first_reg = rt; d.second_reg = rd; end
            F_DS: begin d.first_reg = rd; d.second_reg = rs; end
            F_DT: begin d.first_reg = rd; d.second_reg = rt; end
            F_D: d.first_reg = rd;
            F_S: d.first_reg = rs;
            F_SDT:
            begin
                if (w == 32'd0)
                    d.mnemonic = MN_NOP;
                else
                begin
                    if (alt != 8'd0 && w[21])
                        d.mnemonic = alt;
                    d.first_reg = rd;
                    d.second_reg = rt;
                    d.first_number = {16'd0, sa};
                end
            end
            F_FTS:
            begin
                d.first_reg = rt;
                d.second_reg = rs;
                pos = sa;
                case (w[2:0])
                    3'd0, 3'd3: size = int'(rd) + 1;
                    3'd1: size = int'(rd) + 33;
                    3'd2: begin pos = int'(sa) + 32; size = int'(rd) + 1; end
                    3'd5: size = int'(rd) + 33 - int'(sa);
                    3'd6: begin pos = int'(sa) + 32; size = int'(rd) + 1 - int'(sa); end
                    default: size = int'(rd) + 1 - int'(sa);
                endcase
                // An insert whose msb lies below its lsb has no size.
                if (size < 0)
                    size = 0;
                d.first_number = 21'(pos);
                d.second_number = 7'(size);
            end
            F_BS, F_BTS:
            begin
                d.first_reg = rs;
                if (form == F_BTS)
                    d.second_reg = rt;
                d.target_address = addr + 64'd4 + {{46{w[15]}}, w[15:0], 2'b00};
                d.has_target = 1'b1;
            end
            F_J:
            begin
                d.target_address = {addr[63:28], w[25:0], 2'b00};
                d.has_target = 1'b1;
            end
            F_LT: begin d.first_reg = rt; d.first_number = uimm; end
            F_LTS:
            begin
                if (w[31:26] == OP_ORI && rs == 5'd0)
                begin
                    d.mnemonic = MN_LI;
                    form = F_LT;
                    d.first_reg = rt;
                end
                else
                begin
                    d.first_reg = rt;
                    d.second_reg = rs;
                end
                d.first_number = uimm;
            end
            F_ATS, F_MTS: begin d.first_reg = rt; d.second_reg = rs; d.first_number = simm; end
            F_MS, F_TS: begin d.first_reg = rs; d.first_number = simm; end
            default: d.first_number = {1'b0, w[25:6]};
        endcase
        d.operand_form = form;
        return d;
    endfunction

    // Drives one transaction and waits until the decoder takes it. Valid
    // stays up after the accepting edge so that the next call can follow
    // back to back; it drops only while the sender idles.
    task automatic send_word(input logic [63:0] addr, input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pc <= addr;
        instruction_word <= w;
        pending_decodes.push_back(decode_word(addr, w));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver stall pattern, with a long hold-off counted here whenever
    // the test asks for one.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_served <= 0;
        end
        else if (hold_off_served != hold_off_requests)
        begin
            hold_off_served <= hold_off_requests;
            hold_off_cycles <= HOLD_OFF_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker: compares every completed transaction with the oldest
    // expected decode.
    always @(posedge clk)
    begin
        decode_t got;
        decode_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{decoded, mnemonic, operand_form, first_reg, second_reg, third_reg,
                    first_number, second_number, target_address, has_target};
            result_count <= result_count + 1;
            if (pending_decodes.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("ERROR: unexpected result %h", got);
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (got !== want)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                    begin
                        $display("ERROR: decode mismatch");
                        $display("  expected dec=%0d mn=%0d form=%0d regs=%0d,%0d,%0d",
                                 want.decoded, want.mnemonic, want.operand_form,
                                 want.first_reg, want.second_reg, want.third_reg);
                        $display("           num=%0d size=%0d tgt=%h has=%0d",
                                 want.first_number, want.second_number,
                                 want.target_address, want.has_target);
                        $display("  actual   dec=%0d mn=%0d form=%0d regs=%0d,%0d,%0d",
                                 got.decoded, got.mnemonic, got.operand_form,
                                 got.first_reg, got.second_reg, got.third_reg);
                        $display("           num=%0d size=%0d tgt=%h has=%0d",
                                 got.first_number, got.second_number,
                                 got.target_address, got.has_target);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a transaction and no hold-off runs.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || hold_off_cycles > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("ERROR: watchdog expired with %0d results outstanding",
                     pending_decodes.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [63:0] random_pc();
        return {$urandom, $urandom};
    endfunction

    // Builds a word from a known opcode with random operand bits, so most
    // random traffic lands on real table entries.
    function automatic logic [31:0] random_known_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(6))
            0: w[31:26] = OP_SPC;
            1: w[31:26] = OP_SPC2;
            2: begin w[31:26] = OP_SPC3; w[5:0] = 6'($urandom_range(7)); end
            3:
            begin
                w[31:26] = OP_SPC3;
                w[5:0] = $urandom_range(1) ? FN_BSWAP : FN_DBSWAP;
            end
            4: w[31:26] = OP_RIMM;
            5:
            begin
                // Pseudo-op and rotate neighborhoods.
                case ($urandom_range(3))
                    0: begin w[31:26] = OP_SPC; w[5:0] = FN_OR; w[20:16] = 5'd0; end
                    1: begin w[31:26] = OP_ORI; w[25:21] = 5'd0; end
                    2: begin w[31:26] = OP_SPC; w[25:22] = 4'd0; end
                    default: begin w[31:26] = OP_SPC; w[10:7] = 4'd0; end
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic run_random(input int count);
        repeat (count)
        begin
            if ($urandom_range(9) == 0)
                send_word(random_pc(), $urandom);
            else
                send_word(random_pc(), random_known_word());
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(negedge clk);
    endtask

    // Directed part: extremes, pseudo-ops, rotate alternates, bitfield
    // forms, ill-formed inserts, branch wrap-around and an unknown word.
    task automatic test_directed();
        send_word(64'd0, 32'h0000_0000);                       // nop
        send_word(64'd0, 32'hFFFF_FFFF);                       // unknown
        send_word(64'hFFFF_FFFF_FFFF_FFFC, 32'h1000_7FFF);     // beq, wraps
        send_word(64'h0, 32'h1000_8000);                       // beq, wraps back
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 32'h0BFF_FFFF);     // j, max region
        send_word(64'h1234, {OP_SPC, 5'd3, 5'd0, 5'd7, 5'd0, FN_OR});        // move
        send_word(64'h1234, {OP_ORI, 5'd0, 5'd9, 16'hFFFF});                 // li
        send_word(64'h0, {OP_SPC, 5'd1, 5'd2, 5'd3, 5'd4, 6'h02});           // rotr
        send_word(64'h0, {OP_SPC, 5'd1, 5'd2, 5'd3, 5'd31, 6'h3a});          // drotr
        send_word(64'h0, {OP_SPC, 5'd1, 5'd2, 5'd3, 5'd31, 6'h3e});          // drotr32
        send_word(64'h0, {OP_SPC, 5'd4, 5'd5, 5'd6, 5'd1, 6'h06});           // rotrv
        send_word(64'h0, {OP_SPC, 5'd4, 5'd5, 5'd6, 5'd1, 6'h16});           // drotrv
        send_word(64'h0, {OP_SPC, 5'd4, 5'd0, 5'd6, 5'd1, FN_OR});           // move with R
        send_word(64'h0, {OP_SPC, 5'd31, 5'd31, 10'h3FF, 6'h34});            // teq code
        send_word(64'h0, {OP_SPC, 20'hFFFFF, 6'h0d});                        // break
        send_word(64'h0, {OP_SPC2, 20'hFFFFF, 6'h37});                       // sdbbp
        send_word(64'h0, {OP_SPC3, 5'd1, 5'd2, 5'd31, 5'd31, 6'h01});        // dextm
        send_word(64'h0, {OP_SPC3, 5'd1, 5'd2, 5'd31, 5'd31, 6'h02});        // dextu
        send_word(64'h0, {OP_SPC3, 5'd1, 5'd2, 5'd0, 5'd31, 6'h04});         // bad ins
        send_word(64'h0, {OP_SPC3, 5'd1, 5'd2, 5'd0, 5'd31, 6'h06});         // bad dinsu
        send_word(64'h0, {OP_SPC3, 5'd1, 5'd2, 5'd0, 5'd31, 6'h05});         // dinsm
        send_word(64'h0, {OP_SPC3, 5'd0, 5'd3, 5'd4, 5'h10, FN_BSWAP});      // seb
        send_word(64'h0, {OP_RIMM, 5'd7, 5'h1f, 16'h8000});                  // synci
        send_word(64'h0, {6'h0f, 5'd0, 5'd1, 16'hFFFF});                     // lui
        send_word(64'h0, {6'h08, 5'd1, 5'd2, 16'h8000});                     // addi min
    endtask

    // Receiver holds off for a long stretch while words keep arriving,
    // so the pipeline fills up and stalls its input.
    task automatic test_backpressure();
        hold_off_requests = hold_off_requests + 1;
        run_random(40);
    endtask

    task automatic test_random_phases();
        send_idle_pct = 17;
        recv_idle_pct = 65;
        run_random(450);
        send_idle_pct = 65;
        recv_idle_pct = 17;
        run_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(450);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        pc = '0;
        instruction_word = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random_phases();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d decoded transactions across all opcode tables,", result_count);
        $display("pseudo-ops, rotate alternates, unknown words and long output stalls.");
        if (mismatch_count == 0 && pending_decodes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
